@@ sv/mme_pkg.sv @@
// Package for the matrix multiply engine.
// Holds request codes, register indexes, the sequencer state type and control structs.
// No dependencies; every other file of the block uses it.
package mme_pkg;

  // Default largest matrix dimension held by the element stores.
  localparam int unsigned MAX_DIM_DEF = 16;

  // Fixed field widths of the request, result and register channels.
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned PROD_W  = 2 * ELEM_W;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned CFG_A_W = 2;

  // Request type codes.
  localparam logic [TYPE_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

  // Register indexes.
  localparam logic [CFG_A_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_COLS_B    = 2'd2;

  // Reset value of every size register.
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Store control from the sequencer.
  typedef struct packed {
    logic we_a;
    logic we_b;
    logic re;
  } store_ctl_t;

  // Multiply-accumulate control from the sequencer.
  typedef struct packed {
    logic clear;
    logic rd_valid;
  } mac_ctl_t;

endpackage

@@ sv/mme_if.sv @@
// Handshake channel interfaces of the matrix multiply engine: request, result, register write.
// Depends on mme_pkg for the field widths.
interface mme_req_if;
  logic                              valid;
  logic                              ready;
  logic [mme_pkg::TYPE_W-1:0]        req_type;
  logic [mme_pkg::IDX_W-1:0]         row;
  logic [mme_pkg::IDX_W-1:0]         col;
  logic signed [mme_pkg::ELEM_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface mme_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [mme_pkg::SUM_W-1:0] product_sum;
  logic                             out_of_range;

  modport source (output valid, product_sum, out_of_range, input ready);
  modport sink   (input valid, product_sum, out_of_range, output ready);
endinterface

interface mme_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mme_pkg::CFG_A_W-1:0] index;
  logic [mme_pkg::CFG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mme_store.sv @@
// Element stores for matrices A and B, one write and one registered read port each.
// Depends on mme_pkg for the element width and the control struct.
module mme_store #(
  parameter int unsigned MAX_DIM = mme_pkg::MAX_DIM_DEF,
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
  localparam int unsigned AW     = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  mme_pkg::store_ctl_t               ctl_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] wdata_i,
  input  logic [AW-1:0]                     a_raddr_i,
  input  logic [AW-1:0]                     b_raddr_i,
  output logic signed [mme_pkg::ELEM_W-1:0] a_rdata_o,
  output logic signed [mme_pkg::ELEM_W-1:0] b_rdata_o
);

  logic signed [mme_pkg::ELEM_W-1:0] a_mem [DEPTH];
  logic signed [mme_pkg::ELEM_W-1:0] b_mem [DEPTH];
  logic signed [mme_pkg::ELEM_W-1:0] a_rd_q;
  logic signed [mme_pkg::ELEM_W-1:0] b_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_a) begin
      a_mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      a_rd_q <= a_mem[a_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_b) begin
      b_mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      b_rd_q <= b_mem[b_raddr_i];
    end
  end

  assign a_rdata_o = a_rd_q;
  assign b_rdata_o = b_rd_q;

endmodule

@@ sv/mme_mac.sv @@
// Shared multiply-accumulate unit: one registered 16x16 product and a 40-bit accumulator.
// Depends on mme_pkg for widths and the control struct.
module mme_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mme_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] a_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] b_i,
  output logic signed [mme_pkg::SUM_W-1:0]  acc_o
);

  logic signed [mme_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                              prod_v_q, prod_v_d;
  logic signed [mme_pkg::SUM_W-1:0]  acc_q, acc_d;

  always_comb begin
    prod_d   = mme_pkg::PROD_W'(a_i) * mme_pkg::PROD_W'(b_i);
    prod_v_d = ctl_i.rd_valid && !ctl_i.clear;
    acc_d    = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod_q[mme_pkg::PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= prod_v_d;
      acc_q    <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ sv/mme_seq.sv @@
// Sequencer of the matrix multiply engine: size registers, request decode, inner-index walk
// and the result register. Depends on mme_pkg and the channel interfaces in mme_if.
module mme_seq #(
  parameter int unsigned MAX_DIM = mme_pkg::MAX_DIM_DEF,
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
  localparam int unsigned AW     = $clog2(DEPTH),
  localparam int unsigned IW     = $clog2(MAX_DIM)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mme_req_if.sink                          req_i,
  mme_res_if.source                        res_o,
  mme_cfg_if.sink                          cfg_i,
  output mme_pkg::store_ctl_t              store_ctl_o,
  output logic [AW-1:0]                    waddr_o,
  output logic [AW-1:0]                    a_raddr_o,
  output logic [AW-1:0]                    b_raddr_o,
  output mme_pkg::mac_ctl_t                mac_ctl_o,
  input  logic signed [mme_pkg::SUM_W-1:0] acc_i
);

  // Size registers.
  logic [mme_pkg::CFG_W-1:0] rows_q, inner_q, cols_q;
  logic [mme_pkg::CFG_W-1:0] nr, nk, nc;

  mme_pkg::state_e state_q, state_d;
  logic [IW-1:0]   k_q, k_d;
  logic [AW-1:0]   a_ptr_q, a_ptr_d, b_ptr_q, b_ptr_d;
  logic            issued_q, issued_d;
  logic            drain_q, drain_d;
  logic            oor_q, oor_d;
  logic            out_valid_q, out_valid_d;
  logic signed [mme_pkg::SUM_W-1:0] sum_q, sum_d;
  logic            res_oor_q, res_oor_d;

  logic          req_acc, res_acc, cfg_acc;
  logic          is_write_a, is_write_b, is_compute;
  logic          ok_a, ok_b, oor_req, last_k, out_free;
  logic [IW-1:0] row_idx, col_idx;

  function automatic logic [mme_pkg::CFG_W-1:0] eff_size(input logic [mme_pkg::CFG_W-1:0] r);
    logic [mme_pkg::CFG_W-1:0] s;
    s = (int'(r) > int'(MAX_DIM)) ? mme_pkg::CFG_W'(MAX_DIM) : r;
    return s;
  endfunction

  assign nr = eff_size(rows_q);
  assign nk = eff_size(inner_q);
  assign nc = eff_size(cols_q);

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mme_pkg::CFG_SIZE_RESET;
      inner_q <= mme_pkg::CFG_SIZE_RESET;
      cols_q  <= mme_pkg::CFG_SIZE_RESET;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        mme_pkg::CFG_ROWS_A:    rows_q  <= cfg_i.data;
        mme_pkg::CFG_INNER_LEN: inner_q <= cfg_i.data;
        mme_pkg::CFG_COLS_B:    cols_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Request decode. Indexes are only used once they are known to be below the sizes.
  assign req_i.ready = (state_q == mme_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign res_acc     = res_o.valid && res_o.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  assign is_write_a = (req_i.req_type == mme_pkg::REQ_WRITE_A);
  assign is_write_b = (req_i.req_type == mme_pkg::REQ_WRITE_B);
  assign is_compute = (req_i.req_type == mme_pkg::REQ_COMPUTE);

  assign ok_a    = ({1'b0, req_i.row} < nr) && ({1'b0, req_i.col} < nk);
  assign ok_b    = ({1'b0, req_i.row} < nk) && ({1'b0, req_i.col} < nc);
  assign oor_req = ({1'b0, req_i.row} >= nr) || ({1'b0, req_i.col} >= nc);

  assign row_idx = IW'(req_i.row);
  assign col_idx = IW'(req_i.col);
  assign waddr_o = AW'(int'(row_idx) * int'(MAX_DIM) + int'(col_idx));

  assign last_k = (int'(k_q) + 1) == int'(nk);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mme_pkg::ST_IDLE: begin
        if (req_acc && is_compute) begin
          if (oor_req || (nk == '0)) begin
            state_d = mme_pkg::ST_DONE;
          end else begin
            state_d = mme_pkg::ST_RUN;
          end
        end
      end
      mme_pkg::ST_RUN: begin
        if (last_k) begin
          state_d = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (drain_q) begin
          state_d = mme_pkg::ST_DONE;
        end
      end
      mme_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mme_pkg::ST_IDLE;
        end
      end
      default: state_d = mme_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath registers.
  always_comb begin
    k_d         = k_q;
    a_ptr_d     = a_ptr_q;
    b_ptr_d     = b_ptr_q;
    drain_d     = 1'b0;
    oor_d       = oor_q;
    out_valid_d = out_valid_q && !res_acc;
    sum_d       = sum_q;
    res_oor_d   = res_oor_q;
    issued_d    = (state_q == mme_pkg::ST_RUN);

    store_ctl_o.we_a = 1'b0;
    store_ctl_o.we_b = 1'b0;
    store_ctl_o.re   = (state_q == mme_pkg::ST_RUN);
    mac_ctl_o.clear    = 1'b0;
    mac_ctl_o.rd_valid = issued_q;

    case (state_q)
      mme_pkg::ST_IDLE: begin
        store_ctl_o.we_a = req_acc && is_write_a && ok_a;
        store_ctl_o.we_b = req_acc && is_write_b && ok_b;
        if (req_acc && is_compute) begin
          mac_ctl_o.clear = 1'b1;
          oor_d   = oor_req;
          k_d     = '0;
          a_ptr_d = AW'(int'(row_idx) * int'(MAX_DIM));
          b_ptr_d = AW'(col_idx);
        end
      end
      mme_pkg::ST_RUN: begin
        k_d     = k_q + IW'(1);
        a_ptr_d = a_ptr_q + AW'(1);
        b_ptr_d = b_ptr_q + AW'(MAX_DIM);
      end
      mme_pkg::ST_DRAIN: begin
        drain_d = 1'b1;
      end
      mme_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sum_d       = acc_i;
          res_oor_d   = oor_q;
        end
      end
      default: ;
    endcase
  end

  assign a_raddr_o = a_ptr_q;
  assign b_raddr_o = b_ptr_q;

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    a_ptr_q <= a_ptr_d;
    b_ptr_q <= b_ptr_d;
    sum_q   <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mme_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      drain_q     <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_oor_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      drain_q     <= drain_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
      res_oor_q   <= res_oor_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.product_sum  = sum_q;
  assign res_o.out_of_range = res_oor_q;

endmodule

@@ sv/matrix_multiply_engine.sv @@
// Top level of the matrix multiply engine.
// Depends on mme_pkg, the interfaces in mme_if, and the modules mme_store, mme_mac and mme_seq.

// The engine holds matrices A and B of signed Q2.14 elements in two on-chip stores of
// MAX_DIM x MAX_DIM entries, written one element per request transfer, and computes single
// elements of C = A x B on request. A write to A must satisfy row < rows_a and col < inner_len,
// a write to B row < inner_len and col < cols_b; other writes, and request type 3, are dropped
// silently and produce no result. Size registers above MAX_DIM act as MAX_DIM. A compute request
// whose row is not below rows_a or whose column is not below cols_b returns a sum of zero with
// out_of_range set. Otherwise the engine walks the inner index with one shared 16x16 multiplier
// and a 40-bit accumulator, one term per cycle, and returns the exact sum with 28 fraction bits.
// A compute request occupies the engine while the single multiply-accumulate unit walks the
// inner index through the read, multiply and accumulate register stages, followed by the
// result load. Flagged requests and requests with inner_len of zero skip the walk and go
// straight to the result load. The request channel is not ready while a compute is in flight;
// the finished result sits in an output register, so new write requests are taken while it
// waits for its transfer. Every element that a compute reads must have been written before;
// the stores are not cleared at reset. Size registers may be changed only while the engine
// is idle.
module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  mme_req_if.sink   req_i,
  mme_res_if.source res_o,
  mme_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  mme_pkg::store_ctl_t              store_ctl;
  mme_pkg::mac_ctl_t                mac_ctl;
  logic [AW-1:0]                    waddr, a_raddr, b_raddr;
  logic signed [mme_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [mme_pkg::SUM_W-1:0]  acc;

  // Sequencer: register writes, request decode, inner-index walk and result register.
  mme_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_o       (res_o),
    .cfg_i       (cfg_i),
    .store_ctl_o (store_ctl),
    .waddr_o     (waddr),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .mac_ctl_o   (mac_ctl),
    .acc_i       (acc)
  );

  // Element stores; the write data comes straight from the accepted request.
  mme_store #(
    .MAX_DIM(MAX_DIM)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .waddr_i   (waddr),
    .wdata_i   (req_i.value),
    .a_raddr_i (a_raddr),
    .b_raddr_i (b_raddr),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  // The one multiply-accumulate unit that every term of the dot product goes through.
  mme_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .acc_o  (acc)
  );

endmodule

@@ tb/sv/mme_c_element_checker.sv @@
// Checker for the matrix multiply engine: mirrors both element stores and the size registers,
// predicts each C element from accepted requests and compares it with the result channel.
// Depends on mme_pkg and the channel interfaces of mme_if.
module mme_c_element_checker
  import mme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mme_req_if          req_i,
  mme_res_if          res_i,
  mme_cfg_if          cfg_i,
  output int unsigned errors_o,
  output int unsigned awaited_o,
  output int unsigned checked_o,
  output int unsigned flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SUM_W-1:0] product_sum;
    logic                    out_of_range;
  } c_elem_t;

  logic signed [ELEM_W-1:0] a_mirror [MAX_DIM_DEF*MAX_DIM_DEF];
  logic signed [ELEM_W-1:0] b_mirror [MAX_DIM_DEF*MAX_DIM_DEF];
  logic [CFG_W-1:0]         rows_a_q;
  logic [CFG_W-1:0]         inner_len_q;
  logic [CFG_W-1:0]         cols_b_q;
  c_elem_t                  expected_c_elems [$];

  // Size registers above the store dimension act as the store dimension.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] size);
    return (size > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size);
  endfunction

  function automatic c_elem_t dot_row_col(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    c_elem_t                  elem;
    logic signed [SUM_W-1:0]  acc;
    logic signed [PROD_W-1:0] term;
    int unsigned              k;
    acc = '0;
    elem.out_of_range = 1'b0;
    if (r >= clamp_dim(rows_a_q) || c >= clamp_dim(cols_b_q)) begin
      elem.out_of_range = 1'b1;
    end else begin
      for (k = 0; k < clamp_dim(inner_len_q); k++) begin
        term = a_mirror[r*MAX_DIM_DEF + k] * b_mirror[k*MAX_DIM_DEF + c];
        acc  = acc + term;
      end
    end
    elem.product_sum = acc;
    return elem;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [SUM_W-1:0] want,
                                 input logic signed [SUM_W-1:0] got);
    errors_o++;
    $display("%0t ns: CHECK FAIL %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    c_elem_t want;
    if (!rst_ni) begin
      rows_a_q    = CFG_SIZE_RESET;
      inner_len_q = CFG_SIZE_RESET;
      cols_b_q    = CFG_SIZE_RESET;
      expected_c_elems.delete();
      awaited_o   = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ROWS_A:    rows_a_q    = cfg_i.data;
          CFG_INNER_LEN: inner_len_q = cfg_i.data;
          CFG_COLS_B:    cols_b_q    = cfg_i.data;
          default: ;
        endcase
      end
      // Results are retired before a request of the same edge is predicted.
      if (res_i.valid && res_i.ready) begin
        if (expected_c_elems.size() == 0) begin
          report_mismatch("result transfer with no compute request waiting", '0,
                          res_i.product_sum);
        end else begin
          want = expected_c_elems.pop_front();
          checked_o++;
          if (want.out_of_range) flagged_o++;
          if (res_i.product_sum !== want.product_sum) begin
            report_mismatch("product_sum", want.product_sum, res_i.product_sum);
          end
          if (res_i.out_of_range !== want.out_of_range) begin
            report_mismatch("out_of_range", SUM_W'(want.out_of_range),
                            SUM_W'(res_i.out_of_range));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.req_type)
          REQ_WRITE_A: begin
            if (req_i.row < clamp_dim(rows_a_q) && req_i.col < clamp_dim(inner_len_q)) begin
              a_mirror[req_i.row*MAX_DIM_DEF + req_i.col] = req_i.value;
            end
          end
          REQ_WRITE_B: begin
            if (req_i.row < clamp_dim(inner_len_q) && req_i.col < clamp_dim(cols_b_q)) begin
              b_mirror[req_i.row*MAX_DIM_DEF + req_i.col] = req_i.value;
            end
          end
          REQ_COMPUTE: expected_c_elems.push_back(dot_row_col(req_i.row, req_i.col));
          default: ;
        endcase
      end
      awaited_o = expected_c_elems.size();
    end
  end

endmodule

@@ tb/sv/matrix_multiply_engine_tb.sv @@
// Testbench top for the matrix multiply engine: clock, reset, request and register stimulus,
// result back-pressure, a watchdog and the verdict.
// Depends on mme_pkg, mme_if, the engine RTL and mme_c_element_checker.
module matrix_multiply_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  // Request type 3 and register index 3 have no meaning; the engine must drop them.
  localparam logic [TYPE_W-1:0]  REQ_UNUSED = 2'd3;
  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

  // The settle time after the last result lets a compute in flight finish and the engine return
  // to idle before a register is touched.
  localparam int unsigned SETTLE_CYCLES        = 24;
  localparam int unsigned RX_HOLD_CYCLES       = 300;
  localparam int unsigned SECTION_ITEMS        = 200;
  localparam int unsigned SETTINGS_PER_SECTION = 4;
  // The longest legal quiet stretch is the receiver hold-off; a slow receiver
  // idling 88 percent of the time stays far below this.
  localparam int unsigned WATCHDOG_LIMIT       = 5000;

  logic clk_i;
  logic rst_ni;

  mme_req_if req_ch ();
  mme_res_if res_ch ();
  mme_cfg_if cfg_ch ();

  int unsigned mismatch_count;
  int unsigned awaited_c_elems;
  int unsigned checked_c_elems;
  int unsigned flagged_c_elems;

  // Idle rates in percent per cycle for the request sender and the result receiver.
  int unsigned tx_idle_pct = 9;
  int unsigned rx_idle_pct = 88;
  // Set by the stimulus to make the receiver refuse results for a long stretch.
  logic        rx_hold_go = 1'b0;

  // Sizes last written, used only to steer indices into or out of range.
  logic [CFG_W-1:0] rows_a_set    = CFG_SIZE_RESET;
  logic [CFG_W-1:0] inner_len_set = CFG_SIZE_RESET;
  logic [CFG_W-1:0] cols_b_set    = CFG_SIZE_RESET;

  int unsigned n_write_a;
  int unsigned n_write_b;
  int unsigned n_compute;
  int unsigned n_dropped;
  int unsigned n_settings;

  matrix_multiply_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  mme_c_element_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .res_i     (res_ch),
    .cfg_i     (cfg_ch),
    .errors_o  (mismatch_count),
    .awaited_o (awaited_c_elems),
    .checked_o (checked_c_elems),
    .flagged_o (flagged_c_elems)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned dim_of(input logic [CFG_W-1:0] size);
    return (size > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size);
  endfunction

  // Mostly an index inside the current size, sometimes anything the field can hold.
  function automatic logic [IDX_W-1:0] pick_index(input int unsigned size);
    if (size == 0 || $urandom_range(99) < 15) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom_range(size - 1));
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_element();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return ELEM_MIN;
    if (roll < 10) return ELEM_MAX;
    return ELEM_W'($urandom);
  endfunction

  // Size register values: mostly legal sizes, with zero and saturating values mixed in.
  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return CFG_W'($urandom_range(31, 17));
    if (roll < 30) return CFG_W'(MAX_DIM_DEF);
    return CFG_W'($urandom_range(16, 1));
  endfunction

  // True when the request changes a store or produces a result.
  function automatic bit takes_effect(input logic [TYPE_W-1:0] kind,
                                      input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    case (kind)
      REQ_WRITE_A: return r < dim_of(rows_a_set) && c < dim_of(inner_len_set);
      REQ_WRITE_B: return r < dim_of(inner_len_set) && c < dim_of(cols_b_set);
      REQ_COMPUTE: return 1'b1;
      default:     return 1'b0;
    endcase
  endfunction

  // Offers one request and returns at the edge where it transfers. Valid is left high so
  // that back-to-back requests need only one assignment per edge; an idle gap lowers it.
  task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.row      <= r;
    req_ch.col      <= c;
    req_ch.value    <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    if (!takes_effect(kind, r, c)) n_dropped++;
    else if (kind == REQ_WRITE_A) n_write_a++;
    else if (kind == REQ_WRITE_B) n_write_b++;
    else n_compute++;
  endtask

  // Stops offering requests, waits for every awaited C element and lets the engine settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_c_elems != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Size changes are only legal while the engine is idle, so every change drains first.
  task automatic apply_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                             input logic [CFG_W-1:0] cols);
    drain();
    write_reg(CFG_ROWS_A, rows);
    write_reg(CFG_INNER_LEN, inner);
    write_reg(CFG_COLS_B, cols);
    rows_a_set    = rows;
    inner_len_set = inner;
    cols_b_set    = cols;
    n_settings++;
  endtask

  // Random traffic over several size settings. Only requests that take effect count toward
  // the item budget; dropped ones are still sent as noise.
  task automatic run_random(input int unsigned n_items);
    int unsigned       setting;
    int unsigned       done_items;
    int unsigned       roll;
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    for (setting = 0; setting < SETTINGS_PER_SECTION; setting++) begin
      apply_sizes(pick_size(), pick_size(), pick_size());
      done_items = 0;
      while (done_items < n_items / SETTINGS_PER_SECTION) begin
        roll = $urandom_range(99);
        if (roll < 35) begin
          kind = REQ_WRITE_A;
          r    = pick_index(dim_of(rows_a_set));
          c    = pick_index(dim_of(inner_len_set));
        end else if (roll < 60) begin
          kind = REQ_WRITE_B;
          r    = pick_index(dim_of(inner_len_set));
          c    = pick_index(dim_of(cols_b_set));
        end else if (roll < 95) begin
          kind = REQ_COMPUTE;
          r    = pick_index(dim_of(rows_a_set));
          c    = pick_index(dim_of(cols_b_set));
        end else begin
          kind = REQ_UNUSED;
          r    = IDX_W'($urandom_range(15));
          c    = IDX_W'($urandom_range(15));
        end
        if (takes_effect(kind, r, c)) done_items++;
        send_request(kind, r, c, pick_element());
      end
    end
  endtask

  // The receiver runs on its own: random refusals at the current rate, or a long hold-off
  // counted here once the stimulus asks for one.
  initial begin : result_receiver
    int unsigned hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles, run aborted", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned j;
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_WRITE_A;
    req_ch.row      = '0;
    req_ch.col      = '0;
    req_ch.value    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_ROWS_A;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full sizes first, plus a write to the unused register index, which must do nothing.
    apply_sizes(CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF));
    write_reg(CFG_UNUSED, 5'd31);

    // Every element of both stores gets written before any compute can read it. Row 0 and
    // row 15 of A and columns 0 and 15 of B hold the extreme values, so that the corner
    // elements of C reach the largest positive and the most negative sums.
    for (i = 0; i < MAX_DIM_DEF; i++) begin
      for (j = 0; j < MAX_DIM_DEF; j++) begin
        send_request(REQ_WRITE_A, IDX_W'(i), IDX_W'(j),
                     (i == 0) ? ELEM_MIN : (i == MAX_DIM_DEF - 1) ? ELEM_MAX : pick_element());
        send_request(REQ_WRITE_B, IDX_W'(i), IDX_W'(j),
                     (j == 0) ? ELEM_MIN : (j == MAX_DIM_DEF - 1) ? ELEM_MAX : pick_element());
      end
    end

    // Corner elements of C, an unused request type, and a write followed by a read of it.
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd0, 4'd15, '0);
    send_request(REQ_COMPUTE, 4'd15, 4'd15, '0);
    send_request(REQ_COMPUTE, 4'd15, 4'd0, '0);
    send_request(REQ_UNUSED, 4'd15, 4'd15, ELEM_MIN);
    send_request(REQ_WRITE_A, 4'd9, 4'd4, ELEM_MAX);
    send_request(REQ_WRITE_B, 4'd4, 4'd11, ELEM_MIN);
    send_request(REQ_COMPUTE, 4'd9, 4'd11, '0);

    // Small sizes: writes just past each bound are dropped, computes past a bound are flagged.
    apply_sizes(5'd3, 5'd5, 5'd2);
    send_request(REQ_WRITE_A, 4'd3, 4'd0, ELEM_MAX);
    send_request(REQ_WRITE_A, 4'd0, 4'd5, ELEM_MAX);
    send_request(REQ_WRITE_B, 4'd5, 4'd0, ELEM_MAX);
    send_request(REQ_WRITE_B, 4'd0, 4'd2, ELEM_MAX);
    send_request(REQ_COMPUTE, 4'd3, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd0, 4'd2, '0);
    send_request(REQ_COMPUTE, 4'd2, 4'd1, '0);

    // A zero row count flags every compute and drops every write to A.
    apply_sizes(5'd0, 5'd7, 5'd16);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    send_request(REQ_WRITE_A, 4'd0, 4'd0, '0);

    // A zero inner length gives a zero sum and drops writes to both stores.
    apply_sizes(5'd16, 5'd0, 5'd16);
    send_request(REQ_COMPUTE, 4'd5, 4'd5, '0);
    send_request(REQ_WRITE_B, 4'd0, 4'd0, '0);

    // Register values above the store dimension saturate.
    apply_sizes(5'd31, 5'd31, 5'd31);
    send_request(REQ_COMPUTE, 4'd15, 4'd15, '0);
    send_request(REQ_COMPUTE, 4'd15, 4'd0, '0);

    // Smallest legal sizes.
    apply_sizes(5'd1, 5'd1, 5'd1);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd1, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd0, 4'd1, '0);

    // Slow receiver first, then slow sender, then both at full rate.
    run_random(SECTION_ITEMS);
    tx_idle_pct = 88;
    rx_idle_pct = 9;
    run_random(SECTION_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // The receiver holds off while computes keep coming, so the finished result sits in the
    // output register and the request channel has to stall.
    apply_sizes(CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF));
    rx_hold_go = 1'b1;
    repeat (12) begin
      send_request(REQ_COMPUTE, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                   pick_element());
    end
    run_random(SECTION_ITEMS);

    drain();
    $display("Covered %0d A writes, %0d B writes, %0d computes, %0d dropped requests, %0d sizes.",
             n_write_a, n_write_b, n_compute, n_dropped, n_settings);
    $display("Compared %0d C elements, %0d of them flagged out of range.",
             checked_c_elems, flagged_c_elems);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ matrix_multiply_engine.f @@
sv/mme_pkg.sv
sv/mme_if.sv
sv/mme_store.sv
sv/mme_mac.sv
sv/mme_seq.sv
sv/matrix_multiply_engine.sv
tb/sv/mme_c_element_checker.sv
tb/sv/matrix_multiply_engine_tb.sv
